[src/swoir_pkg.sv]
package swoir_pkg;

    localparam int DEPTH_DEF      = 64;
    localparam int DATA_WIDTH_DEF = 32;

    // field widths of the stream words
    localparam int ACT_W    = 3;
    localparam int WORD_W   = 32;
    localparam int POS_W    = 6;
    localparam int COUNT_W  = 7;
    localparam int STATUS_W = 2;

    localparam int S_DATA_W = 40;   // value_in, position, zero pad
    localparam int M_DATA_W = 72;   // value_out, top_word, entry_count, zero pad

    // boundary index handed to the cells: position + 1 at most
    localparam int BOUND_W = POS_W + 1;

    typedef enum logic [ACT_W-1:0] {
        ACT_PUSH   = 3'd0,
        ACT_POP    = 3'd1,
        ACT_INSERT = 3'd2,
        ACT_REMOVE = 3'd3,
        ACT_CLEAR  = 3'd4
    } t_action;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2,
        ST_RANGE = 2'd3
    } t_status;

    // shift_down: cells below bound hold, cell at bound loads, deeper cells take shallower
    // shift_up:   cells below bound hold, the rest take deeper
    typedef struct packed {
        logic               shift_down;
        logic               shift_up;
        logic [BOUND_W-1:0] bound;
    } t_cell_ctrl;

endpackage

[src/swoir_cell.sv]
module swoir_cell #(
    parameter int DATA_WIDTH = swoir_pkg::DATA_WIDTH_DEF,
    parameter int INDEX      = 0
) (
    input  logic                   i_clk,
    input  swoir_pkg::t_cell_ctrl  i_ctrl,
    input  logic [DATA_WIDTH-1:0]  i_word,
    input  logic [DATA_WIDTH-1:0]  i_shallower,
    input  logic [DATA_WIDTH-1:0]  i_deeper,
    output logic [DATA_WIDTH-1:0]  o_value,
    output logic [DATA_WIDTH-1:0]  o_next
);
    import swoir_pkg::*;

    logic [DATA_WIDTH-1:0] r_value;
    logic                  w_below;
    logic                  w_at;

    assign w_below = INDEX < int'(i_ctrl.bound);
    assign w_at    = INDEX == int'(i_ctrl.bound);

    always_comb begin
        o_next = r_value;
        if (i_ctrl.shift_down && !w_below) begin
            o_next = w_at ? i_word : i_shallower;
        end else if (i_ctrl.shift_up && !w_below) begin
            o_next = i_deeper;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= o_next;
    end

    assign o_value = r_value;

endmodule

[src/stack_with_offset_insert_remove_top.sv]
// Channel   Dir  tdata (low bit up)                                  tuser
// s_axis    in   value_in[31:0], position[37:32], pad[39:38]          action[2:0]
// m_axis    out  value_out[31:0], top_word[63:32], entry_count[70:64] status[1:0]
//
// One word per clock unless the output stalls: every cell compares its index with the
// offset and shifts on acceptance; the result is registered and valid in the next cycle.
// A new word is taken while the result register is empty or being drained.
// Synchronous active-low reset empties the stack and the result register; cell
// contents are not reset and are only read below the count.
module stack_with_offset_insert_remove_top #(
    parameter int DEPTH      = swoir_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = swoir_pkg::DATA_WIDTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [swoir_pkg::S_DATA_W-1:0]  s_axis_tdata,  // value_in, position
    input  logic [swoir_pkg::ACT_W-1:0]     s_axis_tuser,  // action
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [swoir_pkg::M_DATA_W-1:0]  m_axis_tdata,  // value_out, top_word, entry_count
    output logic [swoir_pkg::STATUS_W-1:0]  m_axis_tuser   // status
);
    import swoir_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CMP_W = (CNT_W > POS_W ? CNT_W : POS_W) + 1;

    logic [CNT_W-1:0]      r_count;
    logic [CNT_W-1:0]      n_count;
    logic                  r_out_valid;
    logic [M_DATA_W-1:0]   r_out_data;
    logic [STATUS_W-1:0]   r_out_user;

    logic                  w_accept;
    logic [DATA_WIDTH-1:0] w_word;
    logic [POS_W-1:0]      w_pos;
    logic                  w_full;
    logic                  w_empty;
    logic                  w_in_range;
    logic                  w_ret_sel;
    t_cell_ctrl            w_ctrl;
    t_status               w_status;
    logic [DATA_WIDTH-1:0] w_at_pos;
    logic [DATA_WIDTH-1:0] w_ret;
    logic [DATA_WIDTH-1:0] w_top;

    logic [DATA_WIDTH-1:0] w_cell [DEPTH];
    logic [DATA_WIDTH-1:0] w_next [DEPTH];

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_word        = DATA_WIDTH'(s_axis_tdata[WORD_W-1:0]);
    assign w_pos         = s_axis_tdata[WORD_W+POS_W-1:WORD_W];
    assign w_full        = r_count == CNT_W'(DEPTH);
    assign w_empty       = r_count == '0;
    assign w_in_range    = CMP_W'(w_pos) < CMP_W'(r_count);

    // decode the action into a cell command, new count and status
    always_comb begin
        w_ctrl     = '0;
        w_status   = ST_OK;
        w_ret_sel  = 1'b0;
        n_count    = r_count;
        case (t_action'(s_axis_tuser))
            ACT_PUSH: begin
                if (w_full) begin
                    w_status = ST_FULL;
                end else begin
                    w_ctrl.shift_down = 1'b1;
                    n_count           = r_count + CNT_W'(1);
                end
            end
            ACT_POP: begin
                if (w_empty) begin
                    w_status = ST_EMPTY;
                end else begin
                    w_ctrl.shift_up = 1'b1;
                    w_ret_sel       = 1'b1;
                    n_count         = r_count - CNT_W'(1);
                end
            end
            ACT_INSERT: begin
                if (!w_in_range) begin
                    w_status = ST_RANGE;
                end else if (w_full) begin
                    w_status = ST_FULL;
                end else begin
                    w_ctrl.shift_down = 1'b1;
                    w_ctrl.bound      = BOUND_W'(w_pos) + BOUND_W'(1);
                    n_count           = r_count + CNT_W'(1);
                end
            end
            ACT_REMOVE: begin
                if (!w_in_range) begin
                    w_status = ST_RANGE;
                end else begin
                    w_ctrl.shift_up = 1'b1;
                    w_ctrl.bound    = BOUND_W'(w_pos);
                    w_ret_sel       = 1'b1;
                    n_count         = r_count - CNT_W'(1);
                end
            end
            ACT_CLEAR: begin
                n_count = '0;
            end
            default: begin
            end
        endcase
        if (!w_accept) begin
            w_ctrl  = '0;
            n_count = r_count;
        end
    end

    // pop reads depth zero, remove reads depth position; pop is always issued with position
    // ignored, so select depth zero for it
    always_comb begin
        w_at_pos = '0;
        for (int k = 0; k < DEPTH; k++) begin
            if (k == (t_action'(s_axis_tuser) == ACT_POP ? 0 : int'(w_pos))) begin
                w_at_pos = w_cell[k];
            end
        end
    end

    assign w_ret = w_ret_sel ? w_at_pos : '0;
    assign w_top = (n_count != '0) ? w_next[0] : '0;

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        swoir_cell #(
            .DATA_WIDTH (DATA_WIDTH),
            .INDEX      (g)
        ) u_cell (
            .i_clk       (i_clk),
            .i_ctrl      (w_ctrl),
            .i_word      (w_word),
            .i_shallower (g == 0 ? w_word : w_cell[(g == 0) ? 0 : g - 1]),
            .i_deeper    (g == DEPTH - 1 ? '0 : w_cell[(g == DEPTH - 1) ? g : g + 1]),
            .o_value     (w_cell[g]),
            .o_next      (w_next[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (w_accept) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (w_accept) begin
            r_out_data <= {1'b0, COUNT_W'(n_count), WORD_W'(w_top), WORD_W'(w_ret)};
            r_out_user <= w_status;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_user;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_count) <= DEPTH)
        else $error("stack count beyond depth");

    a_error_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && w_status != ST_OK |=> r_count == $past(r_count))
        else $error("count moved on an error");

    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && t_action'(s_axis_tuser) == ACT_PUSH && !w_full
        |=> r_count == $past(r_count) + CNT_W'(1))
        else $error("push did not grow the stack");

    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(w_accept))
        else $error("result without an accepted word");
`endif

endmodule
